// ----- rtl/prb_pkg.sv -----
// Shared types, constants and the arctangent table for the rotate and bearing pipeline.
package prb_pkg;

    localparam int CORDIC_STAGES = 16;
    localparam int POS_WIDTH     = 24;
    localparam int ANGLE_WIDTH   = 16;

    localparam int ATAN_ENTRIES  = 24;
    localparam int N_ITER        = (CORDIC_STAGES < ATAN_ENTRIES) ? CORDIC_STAGES : ATAN_ENTRIES;
    localparam int STG_W         = 5;

    localparam int GUARD         = 8;
    localparam int GAIN_SH       = 32 - GUARD;
    localparam logic [31:0] KGAIN = 32'd2608131496;

    localparam int PROD_W        = POS_WIDTH + 33;
    localparam int DW            = (PROD_W > 61) ? PROD_W : 61;
    localparam int ZW            = 34;

    localparam int NORM_STEPS    = 6;
    localparam int NSH_W         = 6;
    localparam int NORM_TOP      = 58;

    localparam int IN_BITS       = 4 * POS_WIDTH + 2 * ANGLE_WIDTH;
    localparam int IN_W          = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS      = 2 * POS_WIDTH + ANGLE_WIDTH;
    localparam int OUT_W         = ((OUT_BITS + 7) / 8) * 8;

    localparam logic OP_ROTATE  = 1'b0;
    localparam logic OP_BEARING = 1'b1;

    typedef struct packed {
        logic                          op;
        logic                          zero;
        logic signed [DW-1:0]          x;
        logic signed [DW-1:0]          y;
        logic signed [ZW-1:0]          z;
        logic        [ANGLE_WIDTH-1:0] heading;
    } t_pipe;

    function automatic logic [31:0] cordic_atan(input logic [STG_W-1:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:    v = 32'h20000000;
            5'd1:    v = 32'h12E4051E;
            5'd2:    v = 32'h09FB385B;
            5'd3:    v = 32'h051111D4;
            5'd4:    v = 32'h028B0D43;
            5'd5:    v = 32'h0145D7E1;
            5'd6:    v = 32'h00A2F61E;
            5'd7:    v = 32'h00517C55;
            5'd8:    v = 32'h0028BE53;
            5'd9:    v = 32'h00145F2F;
            5'd10:   v = 32'h000A2F98;
            5'd11:   v = 32'h000517CC;
            5'd12:   v = 32'h00028BE6;
            5'd13:   v = 32'h000145F3;
            5'd14:   v = 32'h0000A2FA;
            5'd15:   v = 32'h0000517D;
            5'd16:   v = 32'h000028BE;
            5'd17:   v = 32'h0000145F;
            5'd18:   v = 32'h00000A30;
            5'd19:   v = 32'h00000518;
            5'd20:   v = 32'h0000028C;
            5'd21:   v = 32'h00000146;
            5'd22:   v = 32'h000000A3;
            5'd23:   v = 32'h00000051;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

// ----- rtl/prb_pre.sv -----
// Front end: gain multiply or difference, then rounding, quadrant fold and zero detect.
module prb_pre
    import prb_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic              i_op,
    input  logic [IN_W-1:0]   i_data,
    output logic              o_valid,
    input  logic              i_ready,
    output t_pipe             o_data
);

    localparam int AW = ANGLE_WIDTH;
    localparam int PW = POS_WIDTH;
    localparam logic signed [DW-1:0] ROUND_K = DW'(1) <<< (GAIN_SH - 1);
    localparam logic signed [ZW-1:0] HALF_Z  = ZW'(1) <<< 31;

    logic signed [PW-1:0]     px, py, tx, ty;
    logic        [AW-1:0]     head, ang, ang_neg;
    logic signed [PROD_W-1:0] prod_x, prod_y;
    logic signed [31:0]       t32;
    logic                     r_a_valid, r_b_valid;
    logic                     a_ready, b_ready;
    t_pipe                    r_a, n_a, r_b, n_b;
    logic signed [DW-1:0]     xr, yr;

    assign px      = i_data[PW-1:0];
    assign py      = i_data[2*PW-1:PW];
    assign head    = i_data[2*PW+AW-1:2*PW];
    assign ang     = i_data[2*PW+2*AW-1:2*PW+AW];
    assign tx      = i_data[3*PW+2*AW-1:2*PW+2*AW];
    assign ty      = i_data[4*PW+2*AW-1:3*PW+2*AW];
    assign ang_neg = AW'(0) - ang;
    assign t32     = {ang_neg, (32 - AW)'(0)};
    assign prod_x  = px * $signed({1'b0, KGAIN});
    assign prod_y  = py * $signed({1'b0, KGAIN});

    assign b_ready = !r_b_valid || i_ready;
    assign a_ready = !r_a_valid || b_ready;
    assign o_ready = a_ready;
    assign o_valid = r_b_valid;
    assign o_data  = r_b;

    always_comb begin
        n_a.op      = i_op;
        n_a.zero    = 1'b0;
        n_a.heading = head;
        if (i_op == OP_ROTATE) begin
            n_a.x = DW'(prod_x);
            n_a.y = DW'(prod_y);
            n_a.z = ZW'(t32);
        end else begin
            n_a.x = DW'(tx) - DW'(px);
            n_a.y = DW'(ty) - DW'(py);
            n_a.z = '0;
        end
    end

    assign xr = (r_a.x + ROUND_K) >>> GAIN_SH;
    assign yr = (r_a.y + ROUND_K) >>> GAIN_SH;

    always_comb begin
        n_b = r_a;
        if (r_a.op == OP_ROTATE) begin
            n_b.x = xr;
            n_b.y = yr;
            if (r_a.z[31] != r_a.z[30]) begin
                n_b.x = -xr;
                n_b.y = -yr;
                n_b.z = r_a.z[ZW-1] ? (r_a.z + HALF_Z) : (r_a.z - HALF_Z);
            end
        end else begin
            n_b.zero = (r_a.x == '0) && (r_a.y == '0);
            if (r_a.x[DW-1]) begin
                n_b.x = -r_a.x;
                n_b.y = -r_a.y;
                n_b.z = HALF_Z;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            if (a_ready) begin
                r_a_valid <= i_valid;
            end
            if (b_ready) begin
                r_b_valid <= r_a_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_ready && i_valid) begin
            r_a <= n_a;
        end
        if (b_ready && r_a_valid) begin
            r_b <= n_b;
        end
    end

endmodule

// ----- rtl/prb_norm_cell.sv -----
// Normalize cell: one conditional left shift of the bearing vector toward the top magnitude.
module prb_norm_cell
    import prb_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [NSH_W-1:0]  i_shift,
    input  logic              i_valid,
    output logic              o_ready,
    input  t_pipe             i_data,
    output logic              o_valid,
    input  logic              i_ready,
    output t_pipe             o_data
);

    logic              r_valid;
    t_pipe             r_data, n_data;
    logic [DW-1:0]     ay, mag;
    logic [6:0]        lim_sh;
    logic              fits;

    assign ay     = i_data.y[DW-1] ? DW'(-i_data.y) : DW'(i_data.y);
    assign mag    = (DW'(i_data.x) > ay) ? DW'(i_data.x) : ay;
    assign lim_sh = 7'(NORM_TOP) - {1'b0, i_shift};
    assign fits   = (mag >> lim_sh) == '0;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_comb begin
        n_data = i_data;
        if ((i_data.op == OP_BEARING) && !i_data.zero && fits) begin
            n_data.x = i_data.x <<< i_shift;
            n_data.y = i_data.y <<< i_shift;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

endmodule

// ----- rtl/prb_cordic_cell.sv -----
// CORDIC cell: one micro-rotation, steered by the angle sign or the y sign.
module prb_cordic_cell
    import prb_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [STG_W-1:0]  i_stage,
    input  logic              i_valid,
    output logic              o_ready,
    input  t_pipe             i_data,
    output logic              o_valid,
    input  logic              i_ready,
    output t_pipe             o_data
);

    logic                 r_valid;
    t_pipe                r_data, n_data;
    logic signed [DW-1:0] xs, ys;
    logic signed [ZW-1:0] at;
    logic                 sel;

    assign xs  = i_data.x >>> i_stage;
    assign ys  = i_data.y >>> i_stage;
    assign at  = $signed(ZW'(cordic_atan(i_stage)));
    assign sel = (i_data.op == OP_BEARING) ? i_data.y[DW-1] : !i_data.z[ZW-1];

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_comb begin
        n_data = i_data;
        if (!i_data.zero) begin
            if (sel) begin
                n_data.x = i_data.x - ys;
                n_data.y = i_data.y + xs;
                n_data.z = i_data.z - at;
            end else begin
                n_data.x = i_data.x + ys;
                n_data.y = i_data.y - xs;
                n_data.z = i_data.z + at;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

endmodule

// ----- rtl/prb_post.sv -----
// Back end: guard rounding and saturation of the point, or rounding and heading offset of the bearing.
module prb_post
    import prb_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  t_pipe                  i_data,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [POS_WIDTH-1:0]   o_out_x,
    output logic [POS_WIDTH-1:0]   o_out_y,
    output logic [ANGLE_WIDTH-1:0] o_bearing
);

    localparam int AW = ANGLE_WIDTH;
    localparam logic signed [DW-1:0] ROUND_G = DW'(1) <<< (GUARD - 1);
    localparam logic signed [DW-1:0] P_MAX   = (DW'(1) <<< (POS_WIDTH - 1)) - DW'(1);
    localparam logic signed [DW-1:0] P_MIN   = -(DW'(1) <<< (POS_WIDTH - 1));

    logic                   r_valid;
    logic [POS_WIDTH-1:0]   r_out_x, r_out_y, n_out_x, n_out_y;
    logic [AW-1:0]          r_bearing, n_bearing;
    logic signed [DW-1:0]   rx, ry;
    logic [31:0]            zr;

    function automatic logic [POS_WIDTH-1:0] sat_pos(input logic signed [DW-1:0] v);
        logic [POS_WIDTH-1:0] s;
        if (v > P_MAX) begin
            s = P_MAX[POS_WIDTH-1:0];
        end else if (v < P_MIN) begin
            s = P_MIN[POS_WIDTH-1:0];
        end else begin
            s = v[POS_WIDTH-1:0];
        end
        return s;
    endfunction

    assign rx = (i_data.x + ROUND_G) >>> GUARD;
    assign ry = (i_data.y + ROUND_G) >>> GUARD;
    assign zr = i_data.z[31:0] + (32'(1) << (31 - AW));

    always_comb begin
        if (i_data.op == OP_ROTATE) begin
            n_out_x   = sat_pos(rx);
            n_out_y   = sat_pos(ry);
            n_bearing = '0;
        end else begin
            n_out_x   = '0;
            n_out_y   = '0;
            n_bearing = zr[31:32-AW] - i_data.heading;
        end
    end

    assign o_ready   = !r_valid || i_ready;
    assign o_valid   = r_valid;
    assign o_out_x   = r_out_x;
    assign o_out_y   = r_out_y;
    assign o_bearing = r_bearing;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_out_x   <= n_out_x;
            r_out_y   <= n_out_y;
            r_bearing <= n_bearing;
        end
    end

endmodule

// ----- rtl/pose_rotate_and_bearing.sv -----
// Top level: pipelined CORDIC for point rotation and pose-relative bearing.
// Takes one transaction per clock while the output is not stalled and returns one result per transaction, in order.
// tuser 0 rotates (pos_x, pos_y) clockwise by rot_angle with gain compensation and
// saturation; tuser 1 returns atan2(target - pos) minus heading as a wrapped binary angle.
// The pipeline has two front-end stages (gain multiply, then round and fold), six
// normalize cells, one CORDIC cell per iteration and an output register. Every stage
// holds its own valid bit, so bubbles collapse under back-pressure and the input keeps
// moving while a result waits at the output.
module pose_rotate_and_bearing
    import prb_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    // pos_x, pos_y, heading, rot_angle, target_x, target_y
    input  logic [IN_W-1:0]  s_axis_tdata,
    // op
    input  logic             s_axis_tuser,
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    // out_x, out_y, bearing
    output logic [OUT_W-1:0] m_axis_tdata
);

    localparam int NCELL = NORM_STEPS + N_ITER;

    logic  c_valid [NCELL+1];
    logic  c_ready [NCELL+1];
    t_pipe c_data  [NCELL+1];

    logic [POS_WIDTH-1:0]   out_x, out_y;
    logic [ANGLE_WIDTH-1:0] bearing;

    prb_pre u_pre (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_op    (s_axis_tuser),
        .i_data  (s_axis_tdata),
        .o_valid (c_valid[0]),
        .i_ready (c_ready[0]),
        .o_data  (c_data[0])
    );

    for (genvar g = 0; g < NORM_STEPS; g++) begin : g_norm
        prb_norm_cell u_norm (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (NSH_W'(1 << (NORM_STEPS - 1 - g))),
            .i_valid (c_valid[g]),
            .o_ready (c_ready[g]),
            .i_data  (c_data[g]),
            .o_valid (c_valid[g+1]),
            .i_ready (c_ready[g+1]),
            .o_data  (c_data[g+1])
        );
    end

    for (genvar g = 0; g < N_ITER; g++) begin : g_iter
        prb_cordic_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_stage (STG_W'(g)),
            .i_valid (c_valid[NORM_STEPS+g]),
            .o_ready (c_ready[NORM_STEPS+g]),
            .i_data  (c_data[NORM_STEPS+g]),
            .o_valid (c_valid[NORM_STEPS+g+1]),
            .i_ready (c_ready[NORM_STEPS+g+1]),
            .o_data  (c_data[NORM_STEPS+g+1])
        );
    end

    prb_post u_post (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (c_valid[NCELL]),
        .o_ready   (c_ready[NCELL]),
        .i_data    (c_data[NCELL]),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_out_x   (out_x),
        .o_out_y   (out_y),
        .o_bearing (bearing)
    );

    assign m_axis_tdata = OUT_W'({bearing, out_y, out_x});

endmodule

// ----- tb/sv/pose_result_checker.sv -----
// Checker that predicts each rotate or bearing result and compares it with the output stream.
`timescale 1ns / 1ps

module pose_result_checker
    import prb_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             s_axis_tvalid,
    input  logic             s_axis_tready,
    // pos_x, pos_y, heading, rot_angle, target_x, target_y
    input  logic [IN_W-1:0]  s_axis_tdata,
    // op
    input  logic             s_axis_tuser,
    input  logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    // out_x, out_y, bearing
    input  logic [OUT_W-1:0] m_axis_tdata,
    output int               o_fail_count,
    output int               o_pending
);

    localparam int     REPORT_LIMIT = 10;
    localparam longint QUARTER_TURN = 64'sd1073741824;
    localparam longint HALF_TURN    = 64'sd2147483648;
    localparam longint NORM_LIMIT   = 64'sd144115188075855872;
    localparam longint POS_LIMIT    = 64'sd1 << (POS_WIDTH - 1);

    typedef struct packed {
        logic signed [ANGLE_WIDTH-1:0] bearing;
        logic signed [POS_WIDTH-1:0]   out_y;
        logic signed [POS_WIDTH-1:0]   out_x;
    } pose_result_t;

    logic [31:0] arctan_step [24] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
        32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
        32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    pose_result_t expected_results[$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    function automatic longint round_shift(input longint v, input int s);
        return (v + (64'sd1 << (s - 1))) >>> s;
    endfunction

    function automatic longint saturate_pos(input longint v);
        if (v >= POS_LIMIT) return POS_LIMIT - 1;
        if (v < -POS_LIMIT) return -POS_LIMIT;
        return v;
    endfunction

    function automatic pose_result_t rotate_point(input logic signed [POS_WIDTH-1:0] px,
                                                  input logic signed [POS_WIDTH-1:0] py,
                                                  input logic [ANGLE_WIDTH-1:0] ang);
        pose_result_t           r;
        longint                 x, y, z, xs, ys, sx, sy;
        logic [ANGLE_WIDTH-1:0] neg_ang;
        logic [31:0]            turn;
        x       = round_shift(longint'(px) * longint'(KGAIN), GAIN_SH);
        y       = round_shift(longint'(py) * longint'(KGAIN), GAIN_SH);
        neg_ang = -ang;
        turn    = {neg_ang, {(32 - ANGLE_WIDTH){1'b0}}};
        z       = longint'($signed(turn));
        if (z >= QUARTER_TURN || z < -QUARTER_TURN) begin
            x = -x;
            y = -y;
            z = (z >= 0) ? z - HALF_TURN : z + HALF_TURN;
        end
        for (int i = 0; i < N_ITER; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
                x = x - ys;
                y = y + xs;
                z = z - longint'(arctan_step[i]);
            end else begin
                x = x + ys;
                y = y - xs;
                z = z + longint'(arctan_step[i]);
            end
        end
        sx        = saturate_pos(round_shift(x, GUARD));
        sy        = saturate_pos(round_shift(y, GUARD));
        r.out_x   = sx[POS_WIDTH-1:0];
        r.out_y   = sy[POS_WIDTH-1:0];
        r.bearing = '0;
        return r;
    endfunction

    function automatic pose_result_t bearing_to_target(input logic signed [POS_WIDTH-1:0] px,
                                                       input logic signed [POS_WIDTH-1:0] py,
                                                       input logic [ANGLE_WIDTH-1:0] hd,
                                                       input logic signed [POS_WIDTH-1:0] tx,
                                                       input logic signed [POS_WIDTH-1:0] ty);
        pose_result_t r;
        longint       x, y, xs, ys, ax, ay;
        logic [31:0]  acc, rounded;
        x   = longint'(tx) - longint'(px);
        y   = longint'(ty) - longint'(py);
        acc = '0;
        if (x != 0 || y != 0) begin
            if (x < 0) begin
                x   = -x;
                y   = -y;
                acc = 32'h80000000;
            end
            ax = (x < 0) ? -x : x;
            ay = (y < 0) ? -y : y;
            while (((ax > ay) ? ax : ay) < NORM_LIMIT) begin
                x  = x * 2;
                y  = y * 2;
                ax = ax * 2;
                ay = ay * 2;
            end
            for (int i = 0; i < N_ITER; i++) begin
                xs = x >>> i;
                ys = y >>> i;
                if (y >= 0) begin
                    x   = x + ys;
                    y   = y - xs;
                    acc = acc + arctan_step[i];
                end else begin
                    x   = x - ys;
                    y   = y + xs;
                    acc = acc - arctan_step[i];
                end
            end
        end
        rounded   = acc + (32'd1 << (31 - ANGLE_WIDTH));
        r.out_x   = '0;
        r.out_y   = '0;
        r.bearing = rounded[31 -: ANGLE_WIDTH] - hd;
        return r;
    endfunction

    function automatic pose_result_t predict_pose_result(input logic op,
                                                         input logic [IN_W-1:0] d);
        if (op == OP_ROTATE)
            return rotate_point(d[0 +: POS_WIDTH], d[POS_WIDTH +: POS_WIDTH],
                                d[2*POS_WIDTH + ANGLE_WIDTH +: ANGLE_WIDTH]);
        return bearing_to_target(d[0 +: POS_WIDTH], d[POS_WIDTH +: POS_WIDTH],
                                 d[2*POS_WIDTH +: ANGLE_WIDTH],
                                 d[2*POS_WIDTH + 2*ANGLE_WIDTH +: POS_WIDTH],
                                 d[3*POS_WIDTH + 2*ANGLE_WIDTH +: POS_WIDTH]);
    endfunction

    always @(posedge i_clk) begin : watch_streams
        pose_result_t got;
        pose_result_t want;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata[OUT_BITS-1:0];
                if (expected_results.size() == 0) begin
                    o_fail_count = o_fail_count + 1;
                    if (o_fail_count <= REPORT_LIMIT)
                        $display("%0t: result with no transaction pending: x %0d y %0d b %0d",
                                 $realtime, got.out_x, got.out_y, got.bearing);
                end else begin
                    want = expected_results.pop_front();
                    if (got.out_x !== want.out_x || got.out_y !== want.out_y ||
                        got.bearing !== want.bearing) begin
                        o_fail_count = o_fail_count + 1;
                        if (o_fail_count <= REPORT_LIMIT)
                            $display("%0t: mismatch x exp %0d got %0d, y exp %0d got %0d, %s%0d got %0d",
                                     $realtime, want.out_x, got.out_x, want.out_y, got.out_y,
                                     "bearing exp ", want.bearing, got.bearing);
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                expected_results.push_back(predict_pose_result(s_axis_tuser, s_axis_tdata));
        end
        o_pending = expected_results.size();
    end

endmodule

// ----- tb/sv/tb_pose_rotate_and_bearing.sv -----
// Top of the rotate and bearing testbench: clock, reset, stimulus, stalls and verdict.
`timescale 1ns / 1ps

module tb_pose_rotate_and_bearing;
    import prb_pkg::*;

    localparam int  RANDOM_ITEMS = 800;
    localparam int  DRAIN_CYCLES = 2 * (9 + CORDIC_STAGES);
    localparam real TIMEOUT_NS   = 10_000_000.0;

    localparam logic signed [POS_WIDTH-1:0]   POS_MAX = {1'b0, {(POS_WIDTH - 1){1'b1}}};
    localparam logic signed [POS_WIDTH-1:0]   POS_MIN = {1'b1, {(POS_WIDTH - 1){1'b0}}};
    localparam logic signed [ANGLE_WIDTH-1:0] ANG_MAX = {1'b0, {(ANGLE_WIDTH - 1){1'b1}}};
    localparam logic signed [ANGLE_WIDTH-1:0] ANG_MIN = {1'b1, {(ANGLE_WIDTH - 1){1'b0}}};
    localparam logic signed [ANGLE_WIDTH-1:0] ANG_QTR = 16'sd16384;
    localparam logic signed [ANGLE_WIDTH-1:0] ANG_8TH = 16'sd8192;

    logic             i_clk;
    logic             i_rst_n;
    logic             s_axis_tvalid;
    logic             s_axis_tready;
    logic [IN_W-1:0]  s_axis_tdata;
    logic             s_axis_tuser;
    logic             m_axis_tvalid;
    logic             m_axis_tready;
    logic [OUT_W-1:0] m_axis_tdata;
    int               fail_count;
    int               pending_count;
    int               burst_left;
    int               ready_hold;

    pose_rotate_and_bearing dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    pose_result_checker checker_0 (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending_count)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // receiver: toggle ready with hold times of its own
    always @(negedge i_clk) begin
        if (ready_hold > 0) begin
            ready_hold = ready_hold - 1;
        end else begin
            m_axis_tready <= !m_axis_tready;
            if (!m_axis_tready)
                ready_hold = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                         : $urandom_range(0, 12);
            else
                ready_hold = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30)
                                                         : $urandom_range(0, 3);
        end
    end

    initial begin
        #(TIMEOUT_NS);
        $display("FAIL");
        $finish;
    end

    function automatic logic signed [POS_WIDTH-1:0] rand_coord();
        case ($urandom_range(0, 9))
            0:       return POS_MAX;
            1:       return POS_MIN;
            2, 3, 4: return POS_WIDTH'($signed($urandom_range(0, 4095)) - 2048);
            default: return POS_WIDTH'($urandom());
        endcase
    endfunction

    function automatic logic signed [ANGLE_WIDTH-1:0] rand_angle();
        case ($urandom_range(0, 11))
            0:       return ANG_MAX;
            1:       return ANG_MIN;
            2:       return ANG_QTR;
            3:       return -ANG_QTR;
            4:       return '0;
            default: return ANGLE_WIDTH'($urandom());
        endcase
    endfunction

    // hold the transaction until accepted, then either keep the burst going or idle
    task automatic send_query(input logic op,
                              input logic signed [POS_WIDTH-1:0] px,
                              input logic signed [POS_WIDTH-1:0] py,
                              input logic signed [ANGLE_WIDTH-1:0] hd,
                              input logic signed [ANGLE_WIDTH-1:0] ra,
                              input logic signed [POS_WIDTH-1:0] tx,
                              input logic signed [POS_WIDTH-1:0] ty);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {ty, tx, ra, hd, py, px};
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
        if (burst_left > 0) begin
            burst_left = burst_left - 1;
        end else begin
            gap = ($urandom_range(0, 3) == 0) ? 0
                : $urandom_range(1, ($urandom_range(0, 5) == 0) ? 20 : 3);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(0, 8);
        end
    endtask

    initial begin
        int                            n;
        logic                          op;
        logic signed [POS_WIDTH-1:0]   px, py, tx, ty;
        logic signed [ANGLE_WIDTH-1:0] hd, ra;
        i_clk         = 1'b0;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tuser  = OP_ROTATE;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        burst_left    = 0;
        ready_hold    = 0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // rotate: zero, extremes, quarter and half turns, saturation at 45 degrees
        send_query(OP_ROTATE, '0, '0, rand_angle(), '0, rand_coord(), rand_coord());
        send_query(OP_ROTATE, POS_MAX, POS_MAX, rand_angle(), '0, rand_coord(), rand_coord());
        send_query(OP_ROTATE, POS_MIN, POS_MIN, rand_angle(), '0, rand_coord(), rand_coord());
        send_query(OP_ROTATE, POS_MAX, '0, rand_angle(), ANG_QTR, rand_coord(), rand_coord());
        send_query(OP_ROTATE, POS_MAX, '0, rand_angle(), -ANG_QTR, rand_coord(), rand_coord());
        send_query(OP_ROTATE, POS_MIN, POS_MAX, rand_angle(), ANG_MIN, rand_coord(), rand_coord());
        send_query(OP_ROTATE, POS_MAX, POS_MAX, rand_angle(), ANG_8TH, rand_coord(), rand_coord());
        send_query(OP_ROTATE, POS_MIN, POS_MIN, rand_angle(), -ANG_8TH, rand_coord(), rand_coord());
        send_query(OP_ROTATE, 24'sd256, -24'sd256, rand_angle(), ANG_MAX, rand_coord(), rand_coord());
        send_query(OP_ROTATE, -24'sd1, 24'sd1, rand_angle(), 16'sd1, rand_coord(), rand_coord());

        // bearing: zero vector, exact half turn, vertical, extreme spans
        send_query(OP_BEARING, 24'sd500, -24'sd77, '0, rand_angle(), 24'sd500, -24'sd77);
        send_query(OP_BEARING, POS_MAX, POS_MIN, ANG_MIN, rand_angle(), POS_MAX, POS_MIN);
        send_query(OP_BEARING, '0, '0, ANG_MAX, rand_angle(), '0, '0);
        send_query(OP_BEARING, 24'sd100, '0, '0, rand_angle(), -24'sd100, '0);
        send_query(OP_BEARING, POS_MAX, 24'sd3, ANG_QTR, rand_angle(), POS_MIN, 24'sd3);
        send_query(OP_BEARING, '0, '0, '0, rand_angle(), '0, 24'sd1);
        send_query(OP_BEARING, '0, '0, -ANG_QTR, rand_angle(), '0, -24'sd1);
        send_query(OP_BEARING, POS_MAX, POS_MAX, ANG_MIN, rand_angle(), POS_MIN, POS_MIN);
        send_query(OP_BEARING, POS_MIN, POS_MIN, ANG_MAX, rand_angle(), POS_MAX, POS_MAX);
        send_query(OP_BEARING, POS_MIN, POS_MAX, ANG_8TH, rand_angle(), POS_MAX, POS_MIN);
        send_query(OP_BEARING, 24'sd10, 24'sd10, '0, rand_angle(), 24'sd3, 24'sd4);
        send_query(OP_BEARING, '0, '0, '0, rand_angle(), 24'sd1, '0);

        for (n = 0; n < RANDOM_ITEMS; n++) begin
            px = rand_coord();
            py = rand_coord();
            tx = rand_coord();
            ty = rand_coord();
            hd = rand_angle();
            ra = rand_angle();
            op = ($urandom_range(0, 1) == 1) ? OP_BEARING : OP_ROTATE;
            if (op == OP_BEARING) begin
                case ($urandom_range(0, 11))
                    0: begin
                        tx = px;
                        ty = py;
                    end
                    1: ty = py;
                    2: tx = px;
                    3: tx = px + POS_WIDTH'($signed($urandom_range(0, 6)) - 3);
                    default: ;
                endcase
            end
            send_query(op, px, py, hd, ra, tx, ty);
        end
        s_axis_tvalid <= 1'b0;

        wait (pending_count == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ----- pose_rotate_and_bearing.f -----
rtl/prb_pkg.sv
rtl/prb_pre.sv
rtl/prb_norm_cell.sv
rtl/prb_cordic_cell.sv
rtl/prb_post.sv
rtl/pose_rotate_and_bearing.sv
tb/sv/pose_result_checker.sv
tb/sv/tb_pose_rotate_and_bearing.sv
